[design/ots_pkg.sv]
package ots_pkg;

  localparam int CAL_BITS_DEF = 8;
  localparam int CAL_BITS_MIN = 7;
  localparam int CAL_BITS_MAX = 10;

  localparam int CNT_W      = 16;
  localparam int ERR_W      = 16;
  localparam int OFS_W      = 8;
  localparam int OUT_CAL_W  = 8;
  localparam int PROD_W     = CNT_W + 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int NSTEPS      = 5;
  localparam int STEP_POS_W  = 3;
  localparam int STEP_VAL_W  = 5;

  localparam int                START_CAL_RST = 128;
  localparam logic [ERR_W-1:0]  TARGET_RST    = 16'd7500;
  localparam logic [ERR_W-1:0]  TOL_RST       = 16'd37;
  localparam logic [ERR_W-1:0]  LIMIT_RST     = 16'd3750;
  localparam logic [OFS_W-1:0]  OFFSET_RST    = 8'd97;
  localparam logic [ERR_W-1:0]  ERR_MAX       = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_CAL = 3'd0,
    REG_TARGET    = 3'd1,
    REG_TOL       = 3'd2,
    REG_LIMIT     = 3'd3,
    REG_OFFSET    = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OUTC_BASE   = 2'd0,
    OUTC_BETTER = 2'd1,
    OUTC_WORSE  = 2'd2,
    OUTC_EQUAL  = 2'd3
  } outcome_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_MUL5,
    OP_ERR,
    OP_UPD,
    OP_PEEK,
    OP_FINISH,
    OP_EMIT,
    OP_REPEAT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_XFER,
    C_DONE,
    C_OUT_RANGE,
    C_FOUND,
    C_OUT_FREE
  } cond_t;

  typedef logic [3:0] pc_t;

  localparam pc_t PC_IDLE = 4'd0;
  localparam pc_t PC_CHK  = 4'd1;
  localparam pc_t PC_ERR  = 4'd2;
  localparam pc_t PC_UPD  = 4'd3;
  localparam pc_t PC_RNG  = 4'd4;
  localparam pc_t PC_PEEK = 4'd5;
  localparam pc_t PC_NOPK = 4'd6;
  localparam pc_t PC_EMIT = 4'd7;
  localparam pc_t PC_REPT = 4'd8;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
    logic  hold;
  } ctrl_word_t;

  typedef struct packed {
    logic no_xfer;
    logic done;
    logic out_range;
    logic found;
    logic exhausted;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic [CNT_W-1:0] measured_count;
  } in_payload_t;

  typedef struct packed {
    logic [OUT_CAL_W-1:0] trial_cal;
    logic [OUT_CAL_W-1:0] best_cal;
    logic [ERR_W-1:0]     best_error;
    outcome_t             outcome;
    logic                 restarted;
    logic                 finished;
  } out_payload_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_payload_t;

  function automatic logic [STEP_VAL_W-1:0] step_val(input logic [STEP_POS_W-1:0] pos);
    logic [STEP_VAL_W-1:0] v;
    case (pos)
      3'd0:    v = 5'd30;
      3'd1:    v = 5'd15;
      3'd2:    v = 5'd5;
      3'd3:    v = 5'd3;
      3'd4:    v = 5'd1;
      default: v = 5'd0;
    endcase
    return v;
  endfunction

  // Microprogram: one control word per step.
  function automatic ctrl_word_t ucode(input pc_t pc);
    ctrl_word_t w;
    case (pc)
      PC_IDLE: w = '{op: OP_NONE,   cond: C_NO_XFER,   target: PC_IDLE, hold: 1'b0};
      PC_CHK:  w = '{op: OP_MUL5,   cond: C_DONE,      target: PC_REPT, hold: 1'b0};
      PC_ERR:  w = '{op: OP_ERR,    cond: C_NEVER,     target: PC_IDLE, hold: 1'b0};
      PC_UPD:  w = '{op: OP_UPD,    cond: C_NEVER,     target: PC_IDLE, hold: 1'b0};
      PC_RNG:  w = '{op: OP_NONE,   cond: C_OUT_RANGE, target: PC_NOPK, hold: 1'b0};
      PC_PEEK: w = '{op: OP_PEEK,   cond: C_FOUND,     target: PC_EMIT, hold: 1'b1};
      PC_NOPK: w = '{op: OP_FINISH, cond: C_NEVER,     target: PC_IDLE, hold: 1'b0};
      PC_EMIT: w = '{op: OP_EMIT,   cond: C_OUT_FREE,  target: PC_IDLE, hold: 1'b1};
      PC_REPT: w = '{op: OP_REPEAT, cond: C_ALWAYS,    target: PC_EMIT, hold: 1'b0};
      default: w = '{op: OP_NONE,   cond: C_ALWAYS,    target: PC_IDLE, hold: 1'b0};
    endcase
    return w;
  endfunction

endpackage

[design/ots_chan_if.sv]
interface ots_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[design/oscillator_trim_search_top.sv]
// One item at a time. A finished search goes straight to its result; else the error is
// computed and the search updated, then a fitting peek is taken, or, with no peek or once
// the step table ends, the search finishes or restarts. The next item is accepted the cycle
// after its result is loaded; the peek loop (one candidate per cycle) and a stalled receiver
// set the rate. Reset: rst_n is synchronous and active low; it loads the register reset values
// and a fresh search from trim 128. A start_cal write also restarts it from the written trim.
module oscillator_trim_search_top #(
  parameter int CAL_BITS = ots_pkg::CAL_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  ots_chan_if.sink          in_ch,
  ots_chan_if.source        out_ch,
  ots_chan_if.sink          cfg_ch
);

  logic [ots_pkg::ERR_W-1:0] target_r;
  logic [ots_pkg::ERR_W-1:0] tol_r;
  logic [ots_pkg::ERR_W-1:0] limit_r;
  logic [ots_pkg::OFS_W-1:0] offset_r;

  ots_pkg::ctrl_word_t   cw;
  ots_pkg::dp_status_t   st;
  ots_pkg::out_payload_t out_pl;
  logic                  idle;
  logic                  in_xfer;
  logic                  cfg_xfer;
  logic                  search_rst;
  logic                  out_valid;

  // hold off both sinks while reset is asserted
  assign in_ch.ready  = idle && rst_n;
  assign in_xfer      = in_ch.valid && idle && rst_n;
  assign cfg_ch.ready = rst_n;
  assign cfg_xfer     = cfg_ch.valid && rst_n;
  assign search_rst   = cfg_xfer &&
                        (cfg_ch.payload.index == ots_pkg::CFG_IDX_W'(ots_pkg::REG_START_CAL));

  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_pl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= ots_pkg::TARGET_RST;
      tol_r    <= ots_pkg::TOL_RST;
      limit_r  <= ots_pkg::LIMIT_RST;
      offset_r <= ots_pkg::OFFSET_RST;
    end else if (cfg_xfer) begin
      unique case (ots_pkg::cfg_reg_t'(cfg_ch.payload.index))
        ots_pkg::REG_TARGET: target_r <= cfg_ch.payload.data;
        ots_pkg::REG_TOL:    tol_r    <= cfg_ch.payload.data;
        ots_pkg::REG_LIMIT:  limit_r  <= cfg_ch.payload.data;
        ots_pkg::REG_OFFSET: offset_r <= cfg_ch.payload.data[ots_pkg::OFS_W-1:0];
        default: begin
          // start_cal goes straight into the search state; other indexes drop
        end
      endcase
    end
  end

  ots_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cw    (cw),
    .idle  (idle)
  );

  ots_dp #(
    .CAL_BITS (CAL_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cw             (cw),
    .in_valid       (in_ch.valid),
    .in_xfer        (in_xfer),
    .in_count       (in_ch.payload.measured_count),
    .search_rst     (search_rst),
    .new_start_cal  (cfg_ch.payload.data[CAL_BITS-1:0]),
    .target_clocks  (target_r),
    .good_tolerance (tol_r),
    .search_limit   (limit_r),
    .restart_offset (offset_r),
    .out_ready      (out_ch.ready),
    .out_valid      (out_valid),
    .out_payload    (out_pl),
    .st             (st)
  );

endmodule

[design/ots_seq.sv]
module ots_seq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ots_pkg::dp_status_t    st,
  output ots_pkg::ctrl_word_t    cw,
  output logic                   idle
);

  ots_pkg::pc_t pc_r;
  ots_pkg::pc_t pc_nxt;
  logic         cond_true;
  logic         hold_eff;

  assign cw   = ots_pkg::ucode(pc_r);
  assign idle = (pc_r == ots_pkg::PC_IDLE);

  always_comb begin
    unique case (cw.cond)
      ots_pkg::C_NEVER:     cond_true = 1'b0;
      ots_pkg::C_ALWAYS:    cond_true = 1'b1;
      ots_pkg::C_NO_XFER:   cond_true = st.no_xfer;
      ots_pkg::C_DONE:      cond_true = st.done;
      ots_pkg::C_OUT_RANGE: cond_true = st.out_range;
      ots_pkg::C_FOUND:     cond_true = st.found;
      ots_pkg::C_OUT_FREE:  cond_true = st.out_free;
      default:              cond_true = 1'b1;
    endcase
  end

  // the peek loop falls through once the step table runs out
  assign hold_eff = cw.hold && !((cw.op == ots_pkg::OP_PEEK) && st.exhausted);

  always_comb begin
    priority if (cond_true) begin
      pc_nxt = cw.target;
    end else if (hold_eff) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = pc_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ots_pkg::PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

[design/ots_dp.sv]
module ots_dp #(
  parameter int CAL_BITS = ots_pkg::CAL_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ots_pkg::ctrl_word_t            cw,
  input  logic                           in_valid,
  input  logic                           in_xfer,
  input  logic [ots_pkg::CNT_W-1:0]      in_count,
  input  logic                           search_rst,
  input  logic [CAL_BITS-1:0]            new_start_cal,
  input  logic [ots_pkg::ERR_W-1:0]      target_clocks,
  input  logic [ots_pkg::ERR_W-1:0]      good_tolerance,
  input  logic [ots_pkg::ERR_W-1:0]      search_limit,
  input  logic [ots_pkg::OFS_W-1:0]      restart_offset,
  input  logic                           out_ready,
  output logic                           out_valid,
  output ots_pkg::out_payload_t          out_payload,
  output ots_pkg::dp_status_t            st
);

  localparam int SW = CAL_BITS + 2;
  localparam logic [CAL_BITS-1:0] WIN_HI_RST  = CAL_BITS'((1 << CAL_BITS) - 2);
  localparam logic [CAL_BITS-1:0] CAL_RST     = CAL_BITS'(ots_pkg::START_CAL_RST);

  logic [ots_pkg::CNT_W-1:0]      cnt_r;
  logic [ots_pkg::PROD_W-1:0]     prod_r;
  logic [ots_pkg::ERR_W-1:0]      err_r;
  logic [CAL_BITS-1:0]            cur_cal_r;
  logic [CAL_BITS-1:0]            origin_r;
  logic [ots_pkg::ERR_W-1:0]      cur_err_r;
  logic                           known_r;
  logic [CAL_BITS-1:0]            win_lo_r;
  logic [CAL_BITS-1:0]            win_hi_r;
  logic [ots_pkg::STEP_POS_W-1:0] step_pos_r;
  logic                           pd_r;
  logic [CAL_BITS-1:0]            peek_r;
  logic                           done_r;
  logic [CAL_BITS-1:0]            trial_r;
  ots_pkg::outcome_t              outcome_r;
  logic                           restarted_r;
  logic                           out_valid_r;
  ots_pkg::out_payload_t          out_pl_r;

  logic [ots_pkg::PROD_W-1:0]     tgt_ext;
  logic [ots_pkg::PROD_W-1:0]     diff;
  logic [ots_pkg::ERR_W-1:0]      err_sat;
  logic                           exhausted;
  logic signed [SW-1:0]           cur_s;
  logic signed [SW-1:0]           lo_s;
  logic signed [SW-1:0]           hi_s;
  logic signed [SW-1:0]           step_s;
  logic signed [SW-1:0]           p_raw;
  logic signed [SW-1:0]           p_hi;
  logic signed [SW-1:0]           p_cl;
  logic                           found;
  logic [CAL_BITS-1:0]            restart_cal;
  logic                           out_free;

  // error = |5*count - target|, saturated
  assign tgt_ext = ots_pkg::PROD_W'(target_clocks);
  assign diff    = (prod_r >= tgt_ext) ? (prod_r - tgt_ext) : (tgt_ext - prod_r);
  assign err_sat = (diff[ots_pkg::PROD_W-1:ots_pkg::ERR_W] != '0) ? ots_pkg::ERR_MAX
                                                                 : diff[ots_pkg::ERR_W-1:0];

  // one peek candidate: step from the table, clamped into the window
  assign exhausted = (step_pos_r >= ots_pkg::STEP_POS_W'(ots_pkg::NSTEPS));
  assign cur_s  = $signed({2'b00, cur_cal_r});
  assign lo_s   = $signed({2'b00, win_lo_r});
  assign hi_s   = $signed({2'b00, win_hi_r});
  assign step_s = $signed({{(SW - ots_pkg::STEP_VAL_W){1'b0}},
                           ots_pkg::step_val(step_pos_r)});
  assign p_raw  = pd_r ? (cur_s - step_s) : (cur_s + step_s);
  assign p_hi   = (p_raw > hi_s) ? hi_s : p_raw;
  assign p_cl   = (p_hi < lo_s) ? lo_s : p_hi;
  assign found  = !exhausted && (pd_r ? (p_cl > lo_s) : (p_cl < hi_s));

  assign restart_cal = origin_r + CAL_BITS'(restart_offset);
  assign out_free    = !out_valid_r || out_ready;

  assign st.no_xfer   = !in_valid;
  assign st.done      = done_r;
  assign st.out_range = !((cur_err_r > good_tolerance) && (cur_err_r < search_limit));
  assign st.found     = found;
  assign st.exhausted = exhausted;
  assign st.out_free  = out_free;

  assign out_valid   = out_valid_r;
  assign out_payload = out_pl_r;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cnt_r <= in_count;
    end
    if (cw.op == ots_pkg::OP_MUL5) begin
      prod_r <= {1'b0, cnt_r, 2'b00} + ots_pkg::PROD_W'(cnt_r);
    end
    if (cw.op == ots_pkg::OP_ERR) begin
      err_r <= err_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || search_rst) begin
      cur_cal_r   <= rst_n ? new_start_cal : CAL_RST;
      origin_r    <= '0;
      cur_err_r   <= '0;
      known_r     <= 1'b0;
      win_lo_r    <= '0;
      win_hi_r    <= WIN_HI_RST;
      step_pos_r  <= '0;
      pd_r        <= 1'b0;
      peek_r      <= '0;
      done_r      <= 1'b0;
      trial_r     <= '0;
      outcome_r   <= ots_pkg::OUTC_BASE;
      restarted_r <= 1'b0;
    end else begin
      unique case (cw.op)
        ots_pkg::OP_MUL5: begin
          restarted_r <= 1'b0;
        end
        ots_pkg::OP_UPD: begin
          priority if (!known_r) begin
            origin_r   <= cur_cal_r;
            cur_err_r  <= err_r;
            known_r    <= 1'b1;
            step_pos_r <= '0;
            pd_r       <= 1'b0;
            outcome_r  <= ots_pkg::OUTC_BASE;
          end else if (err_r < cur_err_r) begin
            if (!pd_r) begin
              win_lo_r <= cur_cal_r;
            end else begin
              win_hi_r <= cur_cal_r;
            end
            cur_cal_r  <= peek_r;
            cur_err_r  <= err_r;
            step_pos_r <= '0;
            pd_r       <= 1'b0;
            outcome_r  <= ots_pkg::OUTC_BETTER;
          end else begin
            if (err_r > cur_err_r) begin
              if (!pd_r) begin
                win_hi_r <= peek_r;
              end else begin
                win_lo_r <= peek_r;
              end
              outcome_r <= ots_pkg::OUTC_WORSE;
            end else begin
              outcome_r <= ots_pkg::OUTC_EQUAL;
            end
            pd_r <= !pd_r;
            if (pd_r && !exhausted) begin
              step_pos_r <= step_pos_r + 3'd1;
            end
          end
        end
        ots_pkg::OP_PEEK: begin
          if (!exhausted) begin
            priority if (found) begin
              peek_r  <= p_cl[CAL_BITS-1:0];
              trial_r <= p_cl[CAL_BITS-1:0];
            end else if (!pd_r) begin
              pd_r <= 1'b1;
            end else begin
              pd_r       <= 1'b0;
              step_pos_r <= step_pos_r + 3'd1;
            end
          end
        end
        ots_pkg::OP_FINISH: begin
          if (cur_err_r > good_tolerance) begin
            cur_cal_r   <= restart_cal;
            trial_r     <= restart_cal;
            known_r     <= 1'b0;
            win_lo_r    <= '0;
            win_hi_r    <= WIN_HI_RST;
            step_pos_r  <= '0;
            pd_r        <= 1'b0;
            restarted_r <= 1'b1;
          end else begin
            done_r  <= 1'b1;
            trial_r <= cur_cal_r;
          end
        end
        ots_pkg::OP_REPEAT: begin
          trial_r     <= cur_cal_r;
          outcome_r   <= ots_pkg::OUTC_BASE;
          restarted_r <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // result register: load on emit, hold until the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cw.op == ots_pkg::OP_EMIT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((cw.op == ots_pkg::OP_EMIT) && out_free) begin
      out_pl_r.trial_cal  <= ots_pkg::OUT_CAL_W'(trial_r);
      out_pl_r.best_cal   <= ots_pkg::OUT_CAL_W'(cur_cal_r);
      out_pl_r.best_error <= known_r ? cur_err_r : ots_pkg::ERR_MAX;
      out_pl_r.outcome    <= outcome_r;
      out_pl_r.restarted  <= restarted_r;
      out_pl_r.finished   <= done_r;
    end
  end

endmodule

[tb/tb_oscillator_trim_search_top.sv]
module tb_oscillator_trim_search_top;
  import ots_pkg::*;

  localparam int CAL_BITS    = CAL_BITS_DEF;
  localparam int CAL_MASK    = (1 << CAL_BITS) - 1;
  localparam int NUM_STEPS   = 5;
  localparam int STEP_TAB[NUM_STEPS] = '{30, 15, 5, 3, 1};
  localparam int RANDOM_ITEMS = 1900;
  localparam int QUIET_FROM   = 1750;
  localparam int HOLD_AT      = 900;
  localparam int HOLD_CYCLES  = 300;
  localparam int WATCHDOG_MAX = 4000;
  localparam int TAIL_CYCLES  = 30;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  class trim_tracker;
    int start_cal, target_clk, tol, limit, offset;
    int cur_cal, origin_cal, cur_err, win_lo, win_hi, step_idx, peek_cal;
    bit err_known, going_down, done;
    int last_trial;
    int fails;
    out_payload_t trim_reports_q[$];

    function new();
      start_cal  = START_CAL_RST;
      target_clk = TARGET_RST;
      tol        = TOL_RST;
      limit      = LIMIT_RST;
      offset     = OFFSET_RST;
      fails      = 0;
      reset_search();
    endfunction

    function void reset_search();
      cur_cal    = start_cal & CAL_MASK;
      origin_cal = 0;
      cur_err    = 0;
      err_known  = 0;
      win_lo     = 0;
      win_hi     = CAL_MASK - 1;
      step_idx   = 0;
      going_down = 0;
      peek_cal   = 0;
      done       = 0;
      last_trial = cur_cal;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_START_CAL: begin
          start_cal = data & CAL_MASK;
          reset_search();
        end
        REG_TARGET: target_clk = data;
        REG_TOL:    tol = data;
        REG_LIMIT:  limit = data;
        REG_OFFSET: offset = data[OFS_W-1:0];
        default: ;
      endcase
    endfunction

    function int error_of(logic [CNT_W-1:0] cnt);
      int clocks, e;
      clocks = 5 * int'(cnt);
      e = (clocks >= target_clk) ? clocks - target_clk : target_clk - clocks;
      return (e > 65535) ? 65535 : e;
    endfunction

    // Advance through the step table until a peek fits inside the window.
    function bit find_peek();
      int p;
      if (!(cur_err > tol && cur_err < limit)) return 0;
      while (step_idx < NUM_STEPS) begin
        p = going_down ? cur_cal - STEP_TAB[step_idx] : cur_cal + STEP_TAB[step_idx];
        if (p > win_hi) p = win_hi;
        if (p < win_lo) p = win_lo;
        if (!going_down) begin
          if (p < win_hi) begin
            peek_cal = p;
            return 1;
          end
          going_down = 1;
        end else begin
          if (p > win_lo) begin
            peek_cal = p;
            return 1;
          end
          going_down = 0;
          step_idx++;
        end
      end
      return 0;
    endfunction

    function void note_count(logic [CNT_W-1:0] cnt);
      out_payload_t want;
      int e, trial;
      outcome_t oc;
      bit rs;
      oc = OUTC_BASE;
      rs = 0;
      if (done) begin
        want.trial_cal  = cur_cal[OUT_CAL_W-1:0];
        want.best_cal   = cur_cal[OUT_CAL_W-1:0];
        want.best_error = cur_err[ERR_W-1:0];
        want.outcome    = OUTC_BASE;
        want.restarted  = 1'b0;
        want.finished   = 1'b1;
        last_trial = cur_cal;
        trim_reports_q.push_back(want);
        return;
      end
      e = error_of(cnt);
      if (!err_known) begin
        origin_cal = cur_cal;
        cur_err    = e;
        err_known  = 1;
        step_idx   = 0;
        going_down = 0;
      end else if (e < cur_err) begin
        if (!going_down) win_lo = cur_cal;
        else win_hi = cur_cal;
        cur_cal    = peek_cal;
        cur_err    = e;
        step_idx   = 0;
        going_down = 0;
        oc = OUTC_BETTER;
      end else begin
        if (e > cur_err) begin
          if (!going_down) win_hi = peek_cal;
          else win_lo = peek_cal;
          oc = OUTC_WORSE;
        end else begin
          oc = OUTC_EQUAL;
        end
        if (!going_down) begin
          going_down = 1;
        end else begin
          going_down = 0;
          if (step_idx < NUM_STEPS) step_idx++;
        end
      end
      if (find_peek()) begin
        trial = peek_cal;
      end else if (cur_err > tol) begin
        // Restart from a new origin.
        cur_cal    = (origin_cal + offset) & CAL_MASK;
        err_known  = 0;
        win_lo     = 0;
        win_hi     = CAL_MASK - 1;
        step_idx   = 0;
        going_down = 0;
        rs = 1;
        trial = cur_cal;
      end else begin
        done = 1;
        trial = cur_cal;
      end
      want.trial_cal  = trial[OUT_CAL_W-1:0];
      want.best_cal   = cur_cal[OUT_CAL_W-1:0];
      want.best_error = err_known ? cur_err[ERR_W-1:0] : ERR_MAX;
      want.outcome    = oc;
      want.restarted  = rs;
      want.finished   = done;
      last_trial = trial;
      trim_reports_q.push_back(want);
    endfunction

    function bit same(string what, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t %s: expected %0d, got %0d", $time, what, want, got);
        return 0;
      end
      return 1;
    endfunction

    function void check_report(out_payload_t got);
      out_payload_t want;
      bit ok;
      if (trim_reports_q.size() == 0) begin
        $display("%0t unexpected result: expected none, got trial_cal %0d", $time,
                 got.trial_cal);
        fails++;
        return;
      end
      want = trim_reports_q.pop_front();
      ok = same("trial_cal", want.trial_cal, got.trial_cal)
         & same("best_cal", want.best_cal, got.best_cal)
         & same("best_error", want.best_error, got.best_error)
         & same("outcome", want.outcome, got.outcome)
         & same("restarted", want.restarted, got.restarted)
         & same("finished", want.finished, got.finished);
      if (!ok) fails++;
    endfunction

    function int pending();
      return trim_reports_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  ots_chan_if #(.payload_t(in_payload_t))  in_ch ();
  ots_chan_if #(.payload_t(out_payload_t)) out_ch ();
  ots_chan_if #(.payload_t(cfg_payload_t)) cfg_ch ();

  oscillator_trim_search_top #(.CAL_BITS(CAL_BITS)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  trim_tracker trk = new();
  cfg_payload_t cfg_plan[$];
  bit send_idle_on = 1'b1;
  bit recv_stall_on = 1'b1;
  bit hold_req = 1'b0;
  int idle_cycles = 0;

  // Oscillator seen by the search: count rises with the trim around an ideal point.
  int ideal_cal, slope, noise_amp;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [CNT_W-1:0] osc_count(int cal);
    int c, jitter;
    jitter = $urandom_range(0, noise_amp);
    c = trk.target_clk / 5 + (slope * (cal - ideal_cal)) / 2 + jitter;
    if (c < 0) c = 0;
    if (c > 65535) c = 65535;
    return c[CNT_W-1:0];
  endfunction

  task automatic plan(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_payload_t w;
    w.index = idx;
    w.data  = data;
    cfg_plan.push_back(w);
  endtask

  // Drain all results, then write the planned registers.
  task automatic flush_cfg();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (trk.pending() != 0);
    foreach (cfg_plan[i]) begin
      cfg_ch.valid   <= 1'b1;
      cfg_ch.payload <= cfg_plan[i];
      do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
      trk.write_reg(cfg_plan[i].index, cfg_plan[i].data);
    end
    cfg_ch.valid <= 1'b0;
    cfg_plan.delete();
  endtask

  task automatic send_count(logic [CNT_W-1:0] cnt);
    in_payload_t p;
    p.measured_count = cnt;
    if (send_idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= p;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    trk.note_count(cnt);
  endtask

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) trk.check_report(out_ch.payload);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && recv_stall_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_MAX) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int n_items, cap, k, extra;
    logic [CNT_W-1:0] cnt;
    bit noisy;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    out_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Exact hit at reset settings, then an ignored item after finishing.
    send_count(16'd1500);
    send_count(16'd0);
    // Trim above the window; saturated error forces a restart.
    plan(REG_START_CAL, 16'd255);
    flush_cfg();
    send_count(16'hFFFF);
    send_count(16'd1600);
    send_count(16'd1550);
    send_count(16'd1700);
    send_count(16'd1550);
    send_count(16'd1520);
    send_count(16'd1501);
    // Upper extremes of target, limit and offset, with tolerance and start trim at zero.
    plan(REG_TARGET, 16'hFFFF);
    plan(REG_TOL, 16'd0);
    plan(REG_LIMIT, 16'hFFFF);
    plan(REG_OFFSET, 16'd255);
    plan(REG_START_CAL, 16'd0);
    flush_cfg();
    send_count(16'd13107);
    plan(REG_START_CAL, 16'd0);
    flush_cfg();
    send_count(16'd0);
    send_count(16'd13000);
    send_count(16'd13100);
    send_count(16'd13106);
    send_count(16'd13107);
    // Lower extremes, tolerance at its top; start_cal writes carry upper bits to drop.
    plan(REG_TARGET, 16'd0);
    plan(REG_TOL, 16'hFFFF);
    plan(REG_LIMIT, 16'd0);
    plan(REG_OFFSET, 16'hFF00);
    plan(REG_START_CAL, 16'hFFFF);
    flush_cfg();
    send_count(16'd0);
    plan(REG_TOL, 16'd0);
    plan(REG_START_CAL, 16'hFF00);
    flush_cfg();
    send_count(16'd1);
    send_count(16'hFFFF);
    // Unused register indexes, then back to reset settings.
    plan(REG_UNUSED_LO, 16'h1234);
    plan(REG_UNUSED_HI, 16'hFFFF);
    plan(REG_TARGET, TARGET_RST);
    plan(REG_TOL, TOL_RST);
    plan(REG_LIMIT, LIMIT_RST);
    plan(REG_OFFSET, OFFSET_RST);
    plan(REG_START_CAL, 16'(START_CAL_RST));
    flush_cfg();

    n_items = 0;
    while (n_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 5))
          0: plan(REG_TARGET, 16'd0);
          1: plan(REG_TARGET, 16'hFFFF);
          2, 3: plan(REG_TARGET, 16'($urandom_range(2000, 20000)));
          default: plan(REG_TARGET, TARGET_RST);
        endcase
        case ($urandom_range(0, 5))
          0: plan(REG_TOL, 16'd0);
          1: plan(REG_TOL, 16'hFFFF);
          2, 3: plan(REG_TOL, 16'($urandom_range(0, 400)));
          default: plan(REG_TOL, TOL_RST);
        endcase
        case ($urandom_range(0, 5))
          0: plan(REG_LIMIT, 16'd0);
          1: plan(REG_LIMIT, 16'hFFFF);
          2, 3: plan(REG_LIMIT, 16'($urandom_range(0, 65535)));
          default: plan(REG_LIMIT, LIMIT_RST);
        endcase
        if ($urandom_range(0, 1) == 0) plan(REG_OFFSET, 16'($urandom_range(0, 65535)));
        else plan(REG_OFFSET, OFFSET_RST);
      end
      plan(REG_START_CAL, 16'($urandom_range(0, 65535)));
      flush_cfg();

      noisy     = ($urandom_range(0, 4) == 0);
      ideal_cal = $urandom_range(0, CAL_MASK);
      slope     = $urandom_range(1, 12);
      noise_amp = $urandom_range(0, 3);
      cap = $urandom_range(15, 70);
      for (k = 0; k < cap && !trk.done && n_items < RANDOM_ITEMS; k++) begin
        if (n_items == HOLD_AT) hold_req = 1'b1;
        if (n_items >= QUIET_FROM) begin
          send_idle_on  = 1'b0;
          recv_stall_on = 1'b0;
        end
        if (noisy || $urandom_range(0, 19) == 0) begin
          case ($urandom_range(0, 7))
            0: cnt = 16'd0;
            1: cnt = 16'hFFFF;
            default: cnt = 16'($urandom_range(0, 65535));
          endcase
        end else begin
          cnt = osc_count(trk.last_trial);
        end
        send_count(cnt);
        n_items++;
      end
      // Items after finishing are ignored by the search.
      if (trk.done) begin
        extra = $urandom_range(0, 2);
        repeat (extra) send_count(16'($urandom_range(0, 65535)));
      end
    end

    in_ch.valid <= 1'b0;
    while (trk.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (trk.fails == 0 && trk.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sim.f]
design/ots_pkg.sv
design/ots_chan_if.sv
design/ots_seq.sv
design/ots_dp.sv
design/oscillator_trim_search_top.sv
tb/tb_oscillator_trim_search_top.sv
